/* design/cell_polygon_classifier_defines.svh */
// ----------------------------------------------------------------------------
// cell polygon classifier assertion macros
// shared property forms for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef CELL_POLYGON_CLASSIFIER_DEFINES_SVH
`define CELL_POLYGON_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk and held off during reset
`define CPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk and held off during reset
`define CPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg
// sizes, request and relation codes, sequencer states and the edge unit
// control group of the cell polygon classifier
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 32;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int MEM_BITS     = 2 * COORD_BITS;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] REL_OUTSIDE   = 2'd0;
    localparam logic [1:0] REL_INSIDE    = 2'd1;
    localparam logic [1:0] REL_INTERSECT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_LOADJ,
        ST_MUL_A,
        ST_MUL_B,
        ST_FINISH,
        ST_CLASSIFY
    } cpc_state_t;

    typedef struct packed {
        logic clear;
        logic load_prev;
        logic mul_a;
        logic mul_b;
    } edge_ctl_t;

endpackage

/* design/cell_polygon_classifier.sv */
// ----------------------------------------------------------------------------
// cell_polygon_classifier
// polygon vertex table with bounding box, even-odd corner test and cell
// classification
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result shows on the
// result ports for one cycle with done high and must be taken then, as the
// receiver cannot stall. Clear, append and unused requests keep busy low and
// give their result in the next cycle. A corner query keeps busy high while
// the sequencer walks every stored polygon edge (with an empty table it goes
// straight to its finish and classify states), and its result follows in the
// cycle busy falls, when the next beat may already be taken. Each edge is
// served by the single 33 x 33 multiplier in two passes, with one vertex
// table entry read per edge.
`include "cell_polygon_classifier_defines.svh"

module cell_polygon_classifier (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            req_type,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] coord_x,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] coord_y,
    input  logic                                  last_corner,
    output logic                                  done,
    output logic                                  status,
    output logic                                  corner_inside,
    output logic                                  relation_valid,
    output logic [1:0]                            relation
);
    import cpc_pkg::*;

    cpc_state_t state_reg, state_next;
    edge_ctl_t  ctl;

    logic [CNT_BITS-1:0]  count_reg, idx_reg;
    logic [CNT_BITS-1:0]  idx_inc, cnt_dec;
    logic [ADDR_BITS-1:0] raddr;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic                         last_reg;
    logic signed [COORD_BITS-1:0] pmin_x_reg, pmax_x_reg, pmin_y_reg, pmax_y_reg;
    logic signed [COORD_BITS-1:0] cmin_x_reg, cmax_x_reg, cmin_y_reg, cmax_y_reg;
    logic                         pending_reg, first_in_reg, mismatch_reg, corner_reg;

    logic                         done_reg, status_reg, cin_reg, rvalid_reg;
    logic [1:0]                   rel_reg;

    logic                         accept, we, corner_in, disjoint;
    logic signed [COORD_BITS-1:0] rx, ry;

    assign accept  = start && !busy;
    assign busy    = state_reg != ST_IDLE;
    assign idx_inc = idx_reg + CNT_BITS'(1);
    assign cnt_dec = count_reg - CNT_BITS'(1);
    assign we      = accept && req_type == REQ_APPEND && count_reg != CNT_BITS'(MAX_VERTICES);

    cpc_vertex_mem u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_BITS-1:0]),
        .wx    (coord_x),
        .wy    (coord_y),
        .raddr (raddr),
        .rx    (rx),
        .ry    (ry)
    );

    cpc_edge_unit u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .rx        (rx),
        .ry        (ry),
        .corner_in (corner_in)
    );

    // edge walk reads the closing vertex first, then vertex 0 upwards
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        raddr      = idx_reg[ADDR_BITS-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_type == REQ_QUERY)
                begin
                    ctl.clear  = 1'b1;
                    state_next = (count_reg == '0) ? ST_FINISH : ST_PRIME;
                end
            end
            ST_PRIME:
            begin
                raddr      = cnt_dec[ADDR_BITS-1:0];
                state_next = ST_LOADJ;
            end
            ST_LOADJ:
            begin
                ctl.load_prev = 1'b1;
                state_next    = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                ctl.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                ctl.mul_b  = 1'b1;
                raddr      = idx_inc[ADDR_BITS-1:0];
                state_next = (idx_inc == count_reg) ? ST_FINISH : ST_MUL_A;
            end
            ST_FINISH:
            begin
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign disjoint = (cmax_x_reg < pmin_x_reg) || (cmin_x_reg > pmax_x_reg) ||
                      (cmax_y_reg < pmin_y_reg) || (cmin_y_reg > pmax_y_reg);

    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_QUERY)
        begin
            qx_reg   <= coord_x;
            qy_reg   <= coord_y;
            last_reg <= last_corner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pmin_x_reg   <= '0;
            pmax_x_reg   <= '0;
            pmin_y_reg   <= '0;
            pmax_y_reg   <= '0;
            cmin_x_reg   <= '0;
            cmax_x_reg   <= '0;
            cmin_y_reg   <= '0;
            cmax_y_reg   <= '0;
            pending_reg  <= 1'b1;
            first_in_reg <= 1'b0;
            mismatch_reg <= 1'b0;
            corner_reg   <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= 1'b0;
            cin_reg      <= 1'b0;
            rvalid_reg   <= 1'b0;
            rel_reg      <= REL_OUTSIDE;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;

            if (accept)
            begin
                idx_reg <= '0;
                if (req_type != REQ_QUERY)
                begin
                    done_reg   <= 1'b1;
                    status_reg <= 1'b0;
                    cin_reg    <= 1'b0;
                    rvalid_reg <= 1'b0;
                    rel_reg    <= REL_OUTSIDE;
                end
                case (req_type)
                    REQ_CLEAR:
                    begin
                        count_reg   <= '0;
                        pmin_x_reg  <= '0;
                        pmax_x_reg  <= '0;
                        pmin_y_reg  <= '0;
                        pmax_y_reg  <= '0;
                        pending_reg <= 1'b1;
                    end
                    REQ_APPEND:
                    begin
                        if (we)
                        begin
                            count_reg <= count_reg + CNT_BITS'(1);
                            if (count_reg == '0)
                            begin
                                pmin_x_reg <= coord_x;
                                pmax_x_reg <= coord_x;
                                pmin_y_reg <= coord_y;
                                pmax_y_reg <= coord_y;
                            end
                            else
                            begin
                                if (coord_x < pmin_x_reg) pmin_x_reg <= coord_x;
                                if (coord_x > pmax_x_reg) pmax_x_reg <= coord_x;
                                if (coord_y < pmin_y_reg) pmin_y_reg <= coord_y;
                                if (coord_y > pmax_y_reg) pmax_y_reg <= coord_y;
                            end
                        end
                        else
                        begin
                            status_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_MUL_B)
            begin
                idx_reg <= idx_inc;
            end

            if (state_reg == ST_FINISH)
            begin
                corner_reg <= corner_in;
                if (pending_reg)
                begin
                    cmin_x_reg   <= qx_reg;
                    cmax_x_reg   <= qx_reg;
                    cmin_y_reg   <= qy_reg;
                    cmax_y_reg   <= qy_reg;
                    first_in_reg <= corner_in;
                    mismatch_reg <= 1'b0;
                    pending_reg  <= 1'b0;
                end
                else
                begin
                    if (qx_reg < cmin_x_reg) cmin_x_reg <= qx_reg;
                    if (qx_reg > cmax_x_reg) cmax_x_reg <= qx_reg;
                    if (qy_reg < cmin_y_reg) cmin_y_reg <= qy_reg;
                    if (qy_reg > cmax_y_reg) cmax_y_reg <= qy_reg;
                    if (corner_in != first_in_reg) mismatch_reg <= 1'b1;
                end
            end

            if (state_reg == ST_CLASSIFY)
            begin
                done_reg   <= 1'b1;
                status_reg <= 1'b0;
                cin_reg    <= corner_reg;
                rvalid_reg <= last_reg;
                if (!last_reg || disjoint)
                begin
                    rel_reg <= REL_OUTSIDE;
                end
                else if (mismatch_reg)
                begin
                    rel_reg <= REL_INTERSECT;
                end
                else
                begin
                    rel_reg <= first_in_reg ? REL_INSIDE : REL_OUTSIDE;
                end
                if (last_reg)
                begin
                    pending_reg <= 1'b1;
                end
            end
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign corner_inside  = cin_reg;
    assign relation_valid = rvalid_reg;
    assign relation       = rel_reg;

    `CPC_ASSERT_IMP(a_done_idle, done, !busy, "result beat while a query is in flight")
    `CPC_ASSERT_NXT(a_short_beat, accept && req_type != REQ_QUERY, done,
        "no result beat after a clear or append")
    `CPC_ASSERT_IMP(a_count_max, 1'b1, count_reg <= CNT_BITS'(MAX_VERTICES),
        "vertex count beyond table size")
    `CPC_ASSERT_IMP(a_rel_idle, done && !relation_valid, relation == REL_OUTSIDE,
        "relation set on a beat without classification")

endmodule

/* design/cpc_vertex_mem.sv */
// ----------------------------------------------------------------------------
// cpc_vertex_mem
// vertex table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cpc_vertex_mem (
    input  logic                                clk,
    input  logic                                we,
    input  logic [cpc_pkg::ADDR_BITS-1:0]       waddr,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] wx,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] wy,
    input  logic [cpc_pkg::ADDR_BITS-1:0]       raddr,
    output logic signed [cpc_pkg::COORD_BITS-1:0] rx,
    output logic signed [cpc_pkg::COORD_BITS-1:0] ry
);
    import cpc_pkg::*;

    logic [MEM_BITS-1:0] mem [MAX_VERTICES];
    logic [MEM_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wx, wy};
        end
        rdata_reg <= mem[raddr];
    end

    assign rx = signed'(rdata_reg[MEM_BITS-1:COORD_BITS]);
    assign ry = signed'(rdata_reg[COORD_BITS-1:0]);

endmodule

/* design/cpc_edge_unit.sv */
// ----------------------------------------------------------------------------
// cpc_edge_unit
// shared multiplier and compare for the crossing test, one edge in two
// passes, with the running even-odd parity
// ----------------------------------------------------------------------------
module cpc_edge_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cpc_pkg::edge_ctl_t                    ctl,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] qx,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] qy,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] rx,
    input  logic signed [cpc_pkg::COORD_BITS-1:0] ry,
    output logic                                  corner_in
);
    import cpc_pkg::*;

    logic signed [COORD_BITS-1:0] xj_reg, yj_reg, xi_reg, yi_reg;
    logic signed [PROD_BITS-1:0]  lhs_reg, rhs_reg;
    logic                         cross_reg, dpos_reg;
    logic                         eval_reg, parity_reg;

    logic signed [DIFF_BITS-1:0]  op_a, op_b;
    logic signed [PROD_BITS-1:0]  prod;
    logic                         hit;

    function automatic logic signed [DIFF_BITS-1:0] ext(input logic signed [COORD_BITS-1:0] v);
        ext = DIFF_BITS'(v);
    endfunction

    // first pass (x - xi) * (yj - yi), second pass (xj - xi) * (y - yi)
    always_comb
    begin
        if (ctl.mul_b)
        begin
            op_a = ext(xj_reg) - ext(xi_reg);
            op_b = ext(qy) - ext(yi_reg);
        end
        else
        begin
            op_a = ext(qx) - ext(rx);
            op_b = ext(yj_reg) - ext(ry);
        end
        prod = op_a * op_b;
    end

    // sign of the edge's dy picks the direction of the compare
    assign hit       = dpos_reg ? (lhs_reg < rhs_reg) : (rhs_reg < lhs_reg);
    assign corner_in = parity_reg ^ (eval_reg & hit);

    always_ff @(posedge clk)
    begin
        if (ctl.load_prev)
        begin
            xj_reg <= rx;
            yj_reg <= ry;
        end
        else if (ctl.mul_b)
        begin
            xj_reg <= xi_reg;
            yj_reg <= yi_reg;
        end
        if (ctl.mul_a)
        begin
            xi_reg    <= rx;
            yi_reg    <= ry;
            lhs_reg   <= prod;
            cross_reg <= (ry > qy) != (yj_reg > qy);
            dpos_reg  <= yj_reg > ry;
        end
        if (ctl.mul_b)
        begin
            rhs_reg <= prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= ctl.mul_b & cross_reg;
            if (ctl.clear)
            begin
                parity_reg <= 1'b0;
            end
            else if (eval_reg)
            begin
                parity_reg <= parity_reg ^ hit;
            end
        end
    end

endmodule

/* sim/cell_polygon_classifier_tb.sv */
// ----------------------------------------------------------------------------
// cell_polygon_classifier_tb
// Drives clear, append and corner beats into the classifier and checks every
// result beat against an in-bench model of the vertex table, the even-odd
// corner test and the cell classification. Directed cases come first, then
// a filled table, then random polygons and cells with noise and gaps.
// ----------------------------------------------------------------------------
module cell_polygon_classifier_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cpc_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         TOTAL_BEATS = 1350;
    localparam int         STALL_LIMIT = 4000;
    localparam longint     COORD_LO    = -64'sd2147483648;
    localparam longint     COORD_HI    = 64'sd2147483647;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic       status;
        logic       corner_in;
        logic       rel_valid;
        logic [1:0] rel;
    } cell_beat_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_type;
    coord_t     coord_x;
    coord_t     coord_y;
    logic       last_corner;
    logic       done;
    logic       status;
    logic       corner_inside;
    logic       relation_valid;
    logic [1:0] relation;

    cell_polygon_classifier u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .last_corner    (last_corner),
        .done           (done),
        .status         (status),
        .corner_inside  (corner_inside),
        .relation_valid (relation_valid),
        .relation       (relation)
    );

    // polygon and cell state as the block should hold it
    coord_t poly_xs [MAX_VERTICES];
    coord_t poly_ys [MAX_VERTICES];
    int     poly_len;
    coord_t poly_lo_x, poly_hi_x, poly_lo_y, poly_hi_y;
    coord_t cell_lo_x, cell_hi_x, cell_lo_y, cell_hi_y;
    logic   awaiting_first_corner;
    logic   first_corner_in;
    logic   corners_disagree;

    cell_beat_t expected_results [$];
    int         beats_sent;
    int         results_seen;
    int         fault_count;
    int         stall_cycles;
    bit         no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // even-odd rule with the crossing division turned into exact products
    function automatic logic corner_parity(coord_t px, coord_t py);
        logic               odd;
        int                 i;
        int                 j;
        longint             xi, yi, xj, yj, x, y, d;
        logic signed [127:0] fa, fb, lhs, rhs;
        logic               crosses;
        odd = 1'b0;
        x   = px;
        y   = py;
        for (i = 0; i < poly_len; i++)
        begin
            j  = (i == 0) ? poly_len - 1 : i - 1;
            xi = poly_xs[i];
            yi = poly_ys[i];
            xj = poly_xs[j];
            yj = poly_ys[j];
            if ((yi > y) != (yj > y))
            begin
                d   = yj - yi;
                fa  = x - xi;
                fb  = d;
                lhs = fa * fb;
                fa  = xj - xi;
                fb  = y - yi;
                rhs = fa * fb;
                crosses = (d > 0) ? (lhs < rhs) : (rhs < lhs);
                if (crosses)
                    odd = ~odd;
            end
        end
        return odd;
    endfunction

    function automatic cell_beat_t classify_beat(logic [1:0] rq, coord_t x, coord_t y,
                                                 logic lc);
        cell_beat_t r;
        logic       hit;
        r = '0;
        case (rq)
            REQ_CLEAR:
            begin
                poly_len  = 0;
                poly_lo_x = '0;
                poly_hi_x = '0;
                poly_lo_y = '0;
                poly_hi_y = '0;
                awaiting_first_corner = 1'b1;
            end
            REQ_APPEND:
            begin
                if (poly_len < MAX_VERTICES)
                begin
                    poly_xs[poly_len] = x;
                    poly_ys[poly_len] = y;
                    if (poly_len == 0)
                    begin
                        poly_lo_x = x;
                        poly_hi_x = x;
                        poly_lo_y = y;
                        poly_hi_y = y;
                    end
                    else
                    begin
                        if (x < poly_lo_x) poly_lo_x = x;
                        if (x > poly_hi_x) poly_hi_x = x;
                        if (y < poly_lo_y) poly_lo_y = y;
                        if (y > poly_hi_y) poly_hi_y = y;
                    end
                    poly_len++;
                end
                else
                    r.status = 1'b1;
            end
            REQ_QUERY:
            begin
                hit = corner_parity(x, y);
                r.corner_in = hit;
                if (awaiting_first_corner)
                begin
                    cell_lo_x = x;
                    cell_hi_x = x;
                    cell_lo_y = y;
                    cell_hi_y = y;
                    first_corner_in  = hit;
                    corners_disagree = 1'b0;
                    awaiting_first_corner = 1'b0;
                end
                else
                begin
                    if (x < cell_lo_x) cell_lo_x = x;
                    if (x > cell_hi_x) cell_hi_x = x;
                    if (y < cell_lo_y) cell_lo_y = y;
                    if (y > cell_hi_y) cell_hi_y = y;
                    if (hit != first_corner_in)
                        corners_disagree = 1'b1;
                end
                if (lc)
                begin
                    r.rel_valid = 1'b1;
                    if (cell_hi_x < poly_lo_x || cell_lo_x > poly_hi_x ||
                        cell_hi_y < poly_lo_y || cell_lo_y > poly_hi_y)
                        r.rel = REL_OUTSIDE;
                    else if (corners_disagree)
                        r.rel = REL_INTERSECT;
                    else
                        r.rel = first_corner_in ? REL_INSIDE : REL_OUTSIDE;
                    awaiting_first_corner = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // result checker: the receiver never stalls, so every done beat is taken
    always @(posedge clk)
    begin
        cell_beat_t want;
        cell_beat_t got;
        if (rst_n && done)
        begin
            got = '{status, corner_inside, relation_valid, relation};
            if (expected_results.size() == 0)
                log_fault($sformatf("result beat %0d with nothing outstanding", results_seen));
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                    log_fault($sformatf({"result beat %0d (exp/got): status %b/%b ",
                        "inside %b/%b valid %b/%b relation %0d/%0d"}, results_seen,
                        want.status, got.status, want.corner_in, got.corner_in,
                        want.rel_valid, got.rel_valid, want.rel, got.rel));
            end
            results_seen++;
        end
    end

    // watchdog on cycles with neither an input nor a result beat
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // each cycle idles with the same odds until one is not skipped
    task automatic sender_gap();
        while (!no_gaps && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_beat(logic [1:0] rq, coord_t x, coord_t y, logic lc);
        start       <= 1'b1;
        req_type    <= rq;
        coord_x     <= x;
        coord_y     <= y;
        last_corner <= lc;
        do
            @(posedge clk);
        while (busy);
        expected_results.insert(expected_results.size(), classify_beat(rq, x, y, lc));
        beats_sent++;
        sender_gap();
    endtask

    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic coord_t rand_near(longint centre, longint spread);
        longint v;
        v = centre + longint'({32'd0, $urandom_range(0, 32'(2 * spread))}) - spread;
        if (v < COORD_LO) v = COORD_LO;
        if (v > COORD_HI) v = COORD_HI;
        return coord_t'(v);
    endfunction

    task automatic test_directed();
        coord_t cmin;
        coord_t cmax;
        cmin = coord_t'(COORD_LO);
        cmax = coord_t'(COORD_HI);
        // empty polygon, single corner cell
        send_beat(REQ_QUERY, 0, 0, 1'b1);
        send_beat(REQ_UNUSED, -1, -1, 1'b1);
        // full-range square, horizontal edges included; last flag ignored on append
        send_beat(REQ_APPEND, cmin, cmin, 1'b1);
        send_beat(REQ_APPEND, cmax, cmin, 1'b0);
        send_beat(REQ_APPEND, cmax, cmax, 1'b0);
        send_beat(REQ_APPEND, cmin, cmax, 1'b0);
        send_beat(REQ_QUERY, 0, 0, 1'b0);
        send_beat(REQ_QUERY, cmax, cmax, 1'b0);
        send_beat(REQ_QUERY, cmin, 0, 1'b1);
        send_beat(REQ_QUERY, 1, -1, 1'b1);
        send_beat(REQ_QUERY, cmax - 1, cmin + 1, 1'b1);
        // triangle, disjoint cell then a straddling one
        send_beat(REQ_CLEAR, 0, 0, 1'b0);
        send_beat(REQ_APPEND, -1000, -1000, 1'b0);
        send_beat(REQ_APPEND, 1000, -1000, 1'b0);
        send_beat(REQ_APPEND, 0, 1000, 1'b0);
        send_beat(REQ_QUERY, 5000, 5000, 1'b1);
        send_beat(REQ_QUERY, 0, 0, 1'b0);
        send_beat(REQ_QUERY, 0, -999, 1'b0);
        send_beat(REQ_QUERY, 2000, 0, 1'b1);
        // clear drops a half-given cell
        send_beat(REQ_QUERY, 0, 0, 1'b0);
        send_beat(REQ_CLEAR, -1, -1, 1'b1);
        send_beat(REQ_QUERY, 9, 9, 1'b1);
        // collinear vertices give a flat polygon
        send_beat(REQ_APPEND, 0, 0, 1'b0);
        send_beat(REQ_APPEND, 10, 10, 1'b0);
        send_beat(REQ_APPEND, 20, 20, 1'b0);
        send_beat(REQ_QUERY, 5, 5, 1'b1);
    endtask

    task automatic test_table_full();
        send_beat(REQ_CLEAR, 0, 0, 1'b0);
        repeat (MAX_VERTICES)
            send_beat(REQ_APPEND, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
        // these are dropped and must not widen the box
        send_beat(REQ_APPEND, coord_t'(COORD_LO), coord_t'(COORD_LO), 1'b0);
        send_beat(REQ_APPEND, coord_t'(COORD_HI), coord_t'(COORD_HI), 1'b1);
        send_beat(REQ_APPEND, $urandom(), $urandom(), 1'b0);
        send_beat(REQ_QUERY, 0, 0, 1'b0);
        send_beat(REQ_QUERY, $urandom(), $urandom(), 1'b0);
        send_beat(REQ_QUERY, coord_t'(COORD_HI), coord_t'(COORD_LO), 1'b1);
        send_beat(REQ_CLEAR, 0, 0, 1'b0);
    endtask

    task automatic test_random_cells();
        int     n;
        int     k;
        int     corners;
        longint cx;
        longint cy;
        longint spread;
        bit     drained_mid;
        drained_mid = 1'b0;
        while (beats_sent < TOTAL_BEATS)
        begin
            no_gaps = (beats_sent >= 600 && beats_sent < 850);
            if (!drained_mid && beats_sent >= 1000)
            begin
                drain_all();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 9) != 0)
                send_beat(REQ_CLEAR, $urandom(), $urandom(), 1'($urandom_range(0, 1)));
            k = $urandom_range(0, 99);
            if (k < 3)
                n = $urandom_range(0, 2);
            else if (k < 88)
                n = $urandom_range(3, 8);
            else if (k < 98)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(100, MAX_VERTICES);
            case ($urandom_range(0, 4))
                0:       spread = 8;
                1:       spread = 200;
                2:       spread = 64'd1 << 16;
                3:       spread = 64'd1 << 24;
                default: spread = 64'd1 << 30;
            endcase
            cx = ($urandom_range(0, 3) == 0) ? 0 : longint'(int'($urandom()));
            cy = ($urandom_range(0, 3) == 0) ? 0 : longint'(int'($urandom()));
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                send_beat(REQ_APPEND, rand_near(cx, spread), rand_near(cy, spread),
                          1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(1, 5))
            begin
                corners = $urandom_range(1, 4);
                for (k = 0; k < corners; k++)
                begin
                    // occasional stray beat breaks the cell
                    if ($urandom_range(0, 29) == 0)
                        send_noise();
                    send_beat(REQ_QUERY, rand_near(cx, spread + spread / 2),
                              rand_near(cy, spread + spread / 2), k == corners - 1);
                end
            end
            if ($urandom_range(0, 9) == 0)
                send_noise();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = REQ_CLEAR;
        coord_x      = '0;
        coord_y      = '0;
        last_corner  = 1'b0;
        poly_len     = 0;
        poly_lo_x    = '0;
        poly_hi_x    = '0;
        poly_lo_y    = '0;
        poly_hi_y    = '0;
        cell_lo_x    = '0;
        cell_hi_x    = '0;
        cell_lo_y    = '0;
        cell_hi_y    = '0;
        awaiting_first_corner = 1'b1;
        first_corner_in       = 1'b0;
        corners_disagree      = 1'b0;
        beats_sent   = 0;
        results_seen = 0;
        fault_count  = 0;
        no_gaps      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        drain_all();
        test_table_full();
        drain_all();
        test_random_cells();
        drain_all();
        repeat (16) @(posedge clk);

        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
